// File: design/hrot_pkg.sv
`timescale 1ns / 1ps

package hrot_pkg;

	// Default fraction width of the internal fixed-point values.
	localparam int FRAC_BITS_DEF = 16;

	// Width of one color component on the pixel ports.
	localparam int PIX_W = 8;

	// Width of the rotation register.
	localparam int ROT_W = 16;

	// Meaningful bits of the rotation register (one turn is 2^15 units).
	localparam int ROT_TURN_W = 15;

	// Which component is the largest; selects the hue sextant base.
	typedef enum logic [1:0] {
		SEXT_RED,
		SEXT_GREEN,
		SEXT_BLUE
	} sext_t;

endpackage

// File: design/hrot_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, several lanes
// in parallel, with a sideband vector that travels along with the data.
// The numerator must not exceed the denominator, so the quotient of
// num * 2^(QW-1) / den fits in QW bits.
module hrot_div #(
	parameter int LANES = 2,
	parameter int DW    = 18,
	parameter int QW    = 17,
	parameter int SW    = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vld_i,
	input  logic [LANES-1:0][DW-1:0]        num,
	input  logic [LANES-1:0][DW-1:0]        den,
	input  logic [SW-1:0]                   side_i,
	output logic                            vld_o,
	output logic [LANES-1:0][QW-1:0]        quo,
	output logic [SW-1:0]                   side_o
);

	logic [QW-1:0]                  vld_s;
	logic [LANES-1:0][DW-1:0]       rem_s  [QW];
	logic [LANES-1:0][DW-1:0]       den_s  [QW];
	logic [LANES-1:0][QW-1:0]       quo_s  [QW];
	logic [SW-1:0]                  side_s [QW];

	logic [LANES-1:0][DW:0]         rem_in  [QW];
	logic [LANES-1:0][DW-1:0]       den_in  [QW];
	logic [LANES-1:0][QW-1:0]       quo_in  [QW];
	logic [LANES-1:0][DW:0]         diff    [QW];
	logic [LANES-1:0][DW-1:0]       rem_nx  [QW];
	logic [LANES-1:0][QW-1:0]       quo_nx  [QW];

	// Trial subtraction in every stage and lane.
	always_comb begin
		for (int k = 0; k < QW; k++) begin
			for (int l = 0; l < LANES; l++) begin
				if (k == 0) begin
					rem_in[k][l] = {1'b0, num[l]};
					den_in[k][l] = den[l];
					quo_in[k][l] = '0;
				end else begin
					rem_in[k][l] = {rem_s[k-1][l], 1'b0};
					den_in[k][l] = den_s[k-1][l];
					quo_in[k][l] = quo_s[k-1][l];
				end
				diff[k][l] = rem_in[k][l] - {1'b0, den_in[k][l]};
				if (!diff[k][l][DW]) begin
					rem_nx[k][l] = diff[k][l][DW-1:0];
					quo_nx[k][l] = {quo_in[k][l][QW-2:0], 1'b1};
				end else begin
					rem_nx[k][l] = rem_in[k][l][DW-1:0];
					quo_nx[k][l] = {quo_in[k][l][QW-2:0], 1'b0};
				end
			end
		end
	end

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QW-2:0], vld_i};
		end
	end

	// Partial remainders, denominators, quotients and sideband.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k] <= rem_nx[k];
				den_s[k] <= den_in[k];
				quo_s[k] <= quo_nx[k];
				side_s[k] <= (k == 0) ? side_i : side_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign vld_o  = vld_s[QW-1];
	assign quo    = quo_s[QW-1];
	assign side_o = side_s[QW-1];

endmodule

// File: design/hrot_rebuild.sv
`timescale 1ns / 1ps

// Back end: hue from the sextant quotient, rotation, m1/m2 and the
// six-sector interpolation, then scaling to 8-bit components.
module hrot_rebuild
	import hrot_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_i,
	input  logic [FRAC_BITS:0]      sat_raw,
	input  logic [FRAC_BITS:0]      quo_h,
	input  logic [FRAC_BITS:0]      lum,
	input  sext_t                   sext,
	input  logic                    neg,
	input  logic                    grey,
	input  logic [ROT_TURN_W-1:0]   rot_turn,
	output logic                    vld_o,
	output logic [PIX_W-1:0]        red_out,
	output logic [PIX_W-1:0]        green_out,
	output logic [PIX_W-1:0]        blue_out
);

	localparam int F = FRAC_BITS;
	localparam logic [F:0]   ONE   = (F+1)'(1) << F;
	localparam logic [F:0]   HALF  = (F+1)'(1) << (F-1);
	// Reciprocal of six for hue = h6 / 6, shift F+3, one correction step.
	localparam int           DIV6_S = F + 3;
	localparam logic [F:0]   DIV6_M = (F+1)'((64'(1) << DIV6_S) / 6);
	localparam int           SHL = (F >= ROT_TURN_W) ? F - ROT_TURN_W : 0;
	localparam int           SHR = (F >= ROT_TURN_W) ? 0 : ROT_TURN_W - F;

	// ---------------- stage 3 ----------------
	logic signed [F+3:0]    base_v;
	logic signed [F+3:0]    h6_v;
	logic [F+2:0]           x_v;
	logic [2*F+3:0]         prod_h;
	logic [F:0]             sat_v;
	logic [2*F+1:0]         ls_v;

	logic                   vld_s3;
	logic [F+2:0]           x_s3;
	logic [F-1:0]           q0_s3;
	logic [F:0]             sat_s3;
	logic [F:0]             lum_s3;
	logic [F:0]             ls_s3;

	// Sextant hue, reciprocal product and lum * sat.
	always_comb begin
		unique case (sext)
			SEXT_RED:   base_v = '0;
			SEXT_GREEN: base_v = (F+4)'(2) << F;
			SEXT_BLUE:  base_v = (F+4)'(4) << F;
			default:    base_v = '0;
		endcase
		if (neg) begin
			h6_v = base_v - signed'({3'b000, quo_h});
		end else begin
			h6_v = base_v + signed'({3'b000, quo_h});
		end
		if (h6_v < 0) begin
			h6_v = h6_v + ((F+4)'(6) << F);
		end
		x_v = grey ? '0 : h6_v[F+2:0];
		prod_h = {1'b0, x_v} * {{(F+3){1'b0}}, DIV6_M};
		if (grey) begin
			sat_v = '0;
		end else if (sat_raw > ONE) begin
			sat_v = ONE;
		end else begin
			sat_v = sat_raw;
		end
		ls_v = {{(F+1){1'b0}}, lum} * {{(F+1){1'b0}}, sat_v};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3   <= x_v;
			q0_s3  <= prod_h[DIV6_S+F-1:DIV6_S];
			sat_s3 <= sat_v;
			lum_s3 <= lum;
			ls_s3  <= ls_v[2*F:F];
		end
	end

	// ---------------- stage 4 ----------------
	logic [F+2:0]           rem6;
	logic [F-1:0]           hue_v;
	logic [F-1:0]           rot_v;
	logic [F+14:0]          rot_w;
	logic [F+1:0]           m2_v;
	logic signed [F+2:0]    m1_v;
	logic signed [F+2:0]    d_v;

	logic                   vld_s4;
	logic [F-1:0]           hue_s4;
	logic signed [F+2:0]    m1_s4;
	logic signed [F+2:0]    m2_s4;
	logic [F+2:0]           d_s4;

	// Correct the hue quotient, rotate it, and form m1 and m2.
	always_comb begin
		rem6 = x_s3 - (({3'b000, q0_s3} << 2) + ({3'b000, q0_s3} << 1));
		hue_v = (rem6 >= (F+3)'(6)) ? q0_s3 + 1'b1 : q0_s3;
		rot_w = ((F+15)'(rot_turn) << SHL) >> SHR;
		rot_v = rot_w[F-1:0];
		if (lum_s3 <= HALF) begin
			m2_v = {1'b0, lum_s3} + {1'b0, ls_s3};
		end else begin
			m2_v = {1'b0, lum_s3} + {1'b0, sat_s3} - {1'b0, ls_s3};
		end
		m1_v = signed'({1'b0, lum_s3, 1'b0}) - signed'({1'b0, m2_v});
		d_v  = signed'({1'b0, m2_v}) - m1_v;
		if (d_v < 0) begin
			d_v = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s4 <= hue_v + rot_v;
			m1_s4  <= m1_v;
			m2_s4  <= signed'({1'b0, m2_v});
			d_s4   <= d_v;
		end
	end

	// ---------------- stage 5 ----------------
	logic [F+2:0]           h6r;
	logic [F-1:0]           frac;
	logic [F:0]             frac_inv;
	logic [2*F+3:0]         pu;
	logic [2*F+3:0]         pd;

	logic                   vld_s5;
	logic [2:0]             sector_s5;
	logic signed [F+2:0]    m1_s5;
	logic signed [F+2:0]    m2_s5;
	logic [F+2:0]           up_s5;
	logic [F+2:0]           down_s5;

	// Sector, position inside it, and the two interpolation products.
	always_comb begin
		h6r      = ({3'b000, hue_s4} << 2) + ({3'b000, hue_s4} << 1);
		frac     = h6r[F-1:0];
		frac_inv = ONE - {1'b0, frac};
		pu = {{(F+1){1'b0}}, d_s4} * {{(F+4){1'b0}}, frac};
		pd = {{(F+1){1'b0}}, d_s4} * {{(F+3){1'b0}}, frac_inv};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s5 <= h6r[F+2:F];
			m1_s5     <= m1_s4;
			m2_s5     <= m2_s4;
			up_s5     <= pu[2*F+2:F];
			down_s5   <= pd[2*F+2:F];
		end
	end

	// ---------------- stage 6 ----------------
	logic signed [F+3:0]    up_v;
	logic signed [F+3:0]    down_v;
	logic signed [F+3:0]    m1_x;
	logic signed [F+3:0]    m2_x;
	logic signed [F+3:0]    ch_v [3];
	logic [PIX_W-1:0]       byte_v [3];
	logic [F+8:0]           scaled [3];

	logic                   vld_s6;
	logic [PIX_W-1:0]       red_s6;
	logic [PIX_W-1:0]       green_s6;
	logic [PIX_W-1:0]       blue_s6;

	// Channel selection by sector and conversion back to 8 bits.
	always_comb begin
		m1_x   = (F+4)'(m1_s5);
		m2_x   = (F+4)'(m2_s5);
		up_v   = m1_x + signed'({1'b0, up_s5});
		down_v = m1_x + signed'({1'b0, down_s5});
		unique case (sector_s5)
			3'd0: begin
				ch_v[0] = m2_x;   ch_v[1] = up_v;   ch_v[2] = m1_x;
			end
			3'd1: begin
				ch_v[0] = down_v; ch_v[1] = m2_x;   ch_v[2] = m1_x;
			end
			3'd2: begin
				ch_v[0] = m1_x;   ch_v[1] = m2_x;   ch_v[2] = up_v;
			end
			3'd3: begin
				ch_v[0] = m1_x;   ch_v[1] = down_v; ch_v[2] = m2_x;
			end
			3'd4: begin
				ch_v[0] = up_v;   ch_v[1] = m1_x;   ch_v[2] = m2_x;
			end
			default: begin
				ch_v[0] = m2_x;   ch_v[1] = m1_x;   ch_v[2] = down_v;
			end
		endcase
		for (int c = 0; c < 3; c++) begin
			scaled[c] = ({{8{1'b0}}, ch_v[c][F:0]} << 8) - {{8{1'b0}}, ch_v[c][F:0]};
			if (ch_v[c] < 0) begin
				byte_v[c] = '0;
			end else if (ch_v[c] > signed'({3'b000, ONE})) begin
				byte_v[c] = '1;
			end else begin
				byte_v[c] = scaled[c][F+7:F];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s6   <= byte_v[0];
			green_s6 <= byte_v[1];
			blue_s6  <= byte_v[2];
		end
	end

	// Valid bits of stages 3 to 6.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_i;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign vld_o     = vld_s6;
	assign red_out   = red_s6;
	assign green_out = green_s6;
	assign blue_out  = blue_s6;

`ifndef SYNTHESIS
	// The reciprocal estimate of h6 / 6 is never more than one too small.
	a_div6_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (rem6 < (F+3)'(12)))
		else $error("hue divide-by-six estimate out of range");

	// Hue below one turn always lands in one of the six sectors.
	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (sector_s5 <= 3'd5))
		else $error("hue sector beyond five");

	// A stalled pipeline keeps its result and its stage contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_s6 && $stable(sector_s5) && $stable(red_s6))
		else $error("pipeline changed while stalled");
`endif

endmodule

// File: design/pixel_hue_rotation_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// pixel in  in_valid / in_ready      red_in, green_in, blue_in (8 bits each)
// pixel out out_valid / out_ready    red_out, green_out, blue_out (8 bits each)
// config    cfg_valid / cfg_ready    hue_rotation (16 bits, signed, 1/32768 turn)
//
// One pixel enters per clock cycle while the output is not stalled; each request
// passes stages 1 and 2, the one-bit-per-stage divider chain and stages 3 to 6.
// Reset clears all valid bits and the rotation register.
// When out_valid is high and out_ready low, every stage holds and in_ready
// drops; no request is lost or repeated. cfg_ready is always high.
module pixel_hue_rotation_unit
	import hrot_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PIX_W-1:0]    red_in,
	input  logic [PIX_W-1:0]    green_in,
	input  logic [PIX_W-1:0]    blue_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PIX_W-1:0]    red_out,
	output logic [PIX_W-1:0]    green_out,
	output logic [PIX_W-1:0]    blue_out,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ROT_W-1:0]    hue_rotation
);

	localparam int F  = FRAC_BITS;
	localparam int DW = F + 2;
	localparam int SW = F + 5;
	localparam logic [F:0]   HALF    = (F+1)'(1) << (F-1);
	localparam logic [F+1:0] TWO_ONE = (F+2)'(1) << (F+1);

	typedef logic [F:0] fx_tab_t [256];

	// ceil(c * 2^F / 255) for every 8-bit component value.
	function automatic fx_tab_t make_fx_tab();
		fx_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = (F+1)'(((longint'(i) << F) + 254) / 255);
		end
		return t;
	endfunction

	localparam fx_tab_t FX_TAB = make_fx_tab();

	logic                   en;
	logic                   vld_o;
	logic [ROT_W-1:0]       hue_rotation_q;

	// Whole pipeline advances unless the result register is stalled.
	assign en        = !vld_o || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_o;
	assign cfg_ready = 1'b1;

	// Rotation register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_rotation_q <= '0;
		end else if (cfg_valid) begin
			hue_rotation_q <= hue_rotation;
		end
	end

	// ---------------- stage 1: components to fixed point ----------------
	logic           vld_s1;
	logic [F:0]     r_s1;
	logic [F:0]     g_s1;
	logic [F:0]     b_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= FX_TAB[red_in];
			g_s1 <= FX_TAB[green_in];
			b_s1 <= FX_TAB[blue_in];
		end
	end

	// ---------------- stage 2: max, min, lightness, divider operands ----
	logic [F:0]     mx;
	logic [F:0]     mn;
	logic [F+1:0]   sum;
	logic [F:0]     delta;
	logic [F:0]     pv;
	logic [F:0]     nv;
	sext_t          sext_v;

	logic                       vld_s2;
	logic [1:0][DW-1:0]         num_s2;
	logic [1:0][DW-1:0]         den_s2;
	logic [SW-1:0]              side_s2;

	always_comb begin
		mx = (r_s1 > g_s1) ? r_s1 : g_s1;
		mn = (r_s1 < g_s1) ? r_s1 : g_s1;
		if (b_s1 > mx) begin
			mx = b_s1;
		end
		if (b_s1 < mn) begin
			mn = b_s1;
		end
		sum   = {1'b0, mx} + {1'b0, mn};
		delta = mx - mn;
		priority if (r_s1 == mx) begin
			sext_v = SEXT_RED;
			pv = g_s1;
			nv = b_s1;
		end else if (g_s1 == mx) begin
			sext_v = SEXT_GREEN;
			pv = b_s1;
			nv = r_s1;
		end else begin
			sext_v = SEXT_BLUE;
			pv = r_s1;
			nv = g_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Lane 0: saturation, lane 1: hue offset inside the sextant.
			num_s2[0] <= {1'b0, delta};
			den_s2[0] <= (sum[F+1:1] <= HALF) ? sum : TWO_ONE - sum;
			num_s2[1] <= (pv >= nv) ? {1'b0, pv - nv} : {1'b0, nv - pv};
			den_s2[1] <= {1'b0, delta};
			side_s2   <= {sum[F+1:1], sext_v, (pv < nv), (delta == '0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// ---------------- divider chain ----------------
	logic                       div_vld;
	logic [1:0][F:0]            div_quo;
	logic [SW-1:0]              div_side;

	hrot_div #(
		.LANES (2),
		.DW    (DW),
		.QW    (F + 1),
		.SW    (SW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s2),
		.num    (num_s2),
		.den    (den_s2),
		.side_i (side_s2),
		.vld_o  (div_vld),
		.quo    (div_quo),
		.side_o (div_side)
	);

	// ---------------- back end ----------------
	hrot_rebuild #(
		.FRAC_BITS (F)
	) u_rebuild (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_i     (div_vld),
		.sat_raw   (div_quo[0]),
		.quo_h     (div_quo[1]),
		.lum       (div_side[SW-1:4]),
		.sext      (sext_t'(div_side[3:2])),
		.neg       (div_side[1]),
		.grey      (div_side[0]),
		.rot_turn  (hue_rotation_q[ROT_TURN_W-1:0]),
		.vld_o     (vld_o),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

// Scoreboard: predicts the rotated pixel for every accepted input pixel and
// compares results in order.
class hue_scoreboard;
	localparam int FB = hrot_pkg::FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FB;

	logic [15:0] rotation;
	logic [23:0] pending[$];
	int errors;

	function new();
		rotation = '0;
		errors = 0;
	endfunction

	// Scale an 8-bit component to a fraction, rounding up.
	function longint to_frac(logic [7:0] c);
		return (longint'(c) * ONE + 254) / 255;
	endfunction

	// Scale a fraction back to 8 bits with truncation and clamping.
	function logic [7:0] to_pix(longint v);
		if (v < 0) begin
			return 8'd0;
		end
		if (v > ONE) begin
			return 8'd255;
		end
		return 8'((v * 255) >>> FB);
	endfunction

	function longint sext_hue(longint base, longint p, longint n, longint dl);
		if (p >= n) begin
			return base * ONE + ((p - n) * ONE) / dl;
		end
		return base * ONE - ((n - p) * ONE) / dl;
	endfunction

	// Work out the rotated pixel and queue it.
	function void note_pixel(logic [7:0] rin, logic [7:0] gin, logic [7:0] bin);
		longint r, g, b, mx, mn, sum, lum, dl, sat, hue, h6, den, m1, m2, d, fr;
		longint up, dn, ro, go, bo, rot;
		longint sector;
		r = to_frac(rin);
		g = to_frac(gin);
		b = to_frac(bin);
		mx = (r > g) ? r : g;
		mn = (r < g) ? r : g;
		if (b > mx) mx = b;
		if (b < mn) mn = b;
		sum = mx + mn;
		lum = sum >>> 1;
		dl = mx - mn;
		sat = 0;
		hue = 0;
		// Saturation and hue exist only for colored pixels.
		if (dl > 0) begin
			den = (lum <= (ONE >>> 1)) ? sum : 2 * ONE - sum;
			sat = (den > 0) ? (dl * ONE) / den : ONE;
			if (sat > ONE) sat = ONE;
			if (r == mx) h6 = sext_hue(0, g, b, dl);
			else if (g == mx) h6 = sext_hue(2, b, r, dl);
			else h6 = sext_hue(4, r, g, dl);
			if (h6 < 0) h6 += 6 * ONE;
			hue = h6 / 6;
		end
		// Apply the rotation modulo one turn.
		rot = longint'(rotation[14:0]);
		if (FB >= 15) rot = rot << (FB - 15);
		else rot = rot >> (15 - FB);
		hue = (hue + rot) & (ONE - 1);
		h6 = hue * 6;
		sector = h6 >>> FB;
		fr = h6 & (ONE - 1);
		if (lum <= (ONE >>> 1)) m2 = lum + ((lum * sat) >>> FB);
		else m2 = lum + sat - ((lum * sat) >>> FB);
		m1 = 2 * lum - m2;
		d = m2 - m1;
		if (d < 0) d = 0;
		up = m1 + ((d * fr) >>> FB);
		dn = m1 + ((d * (ONE - fr)) >>> FB);
		case (sector)
			0: begin ro = m2; go = up; bo = m1; end
			1: begin ro = dn; go = m2; bo = m1; end
			2: begin ro = m1; go = m2; bo = up; end
			3: begin ro = m1; go = dn; bo = m2; end
			4: begin ro = up; go = m1; bo = m2; end
			default: begin ro = m2; go = m1; bo = dn; end
		endcase
		pending.push_back({to_pix(ro), to_pix(go), to_pix(bo)});
	endfunction

	// Compare one result with the oldest expectation.
	function void check_pixel(logic [7:0] ro, logic [7:0] go, logic [7:0] bo);
		logic [23:0] e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h %h %h", $time, ro, go, bo);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (e[23:16] !== ro) begin
			$display("%0t: red expected %0d actual %0d", $time, e[23:16], ro);
			errors++;
		end
		if (e[15:8] !== go) begin
			$display("%0t: green expected %0d actual %0d", $time, e[15:8], go);
			errors++;
		end
		if (e[7:0] !== bo) begin
			$display("%0t: blue expected %0d actual %0d", $time, e[7:0], bo);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import hrot_pkg::*;

	localparam int LATENCY = FRAC_BITS_DEF + 7;
	localparam longint LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PIX_W-1:0] red_in = '0, green_in = '0, blue_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PIX_W-1:0] red_out, green_out, blue_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ROT_W-1:0] hue_rotation = '0;

	hue_scoreboard sb;
	longint cycles = 0;
	bit quiet = 1'b0;
	bit long_hold = 1'b0;

	pixel_hue_rotation_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.hue_rotation(hue_rotation)
	);

	always #10 clk = ~clk;

	// Note accepted requests and check results at the rising edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && in_valid && in_ready) begin
			sb.note_pixel(red_in, green_in, blue_in);
		end
		if (arst_n && out_valid && out_ready) begin
			sb.check_pixel(red_out, green_out, blue_out);
		end
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold, none in the quiet part.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (200) @(negedge clk);
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 19);
				out_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Send one pixel and hold it until accepted.
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int n;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Wait for all results and let the pipeline settle; write_rotation then writes the register.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_rotation(logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		hue_rotation <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.rotation = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_pixels(int count);
		logic [7:0] r, g, b;
		int k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 9);
			r = 8'($urandom);
			g = 8'($urandom);
			b = 8'($urandom);
			// Mix in grey pixels, extremes and ties between components.
			if (k == 0) begin
				g = r;
				b = r;
			end else if (k == 1) begin
				r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end else if (k == 2) begin
				g = r;
			end
			send_pixel(r, g, b);
		end
	endtask

	initial begin
		logic [15:0] rots[8];
		sb = new();
		rots = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h1555, 16'h4000,
			16'h2AAB, 16'hC000};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pixels at the reset rotation: greys, primaries, ties.
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd200, 8'd100, 8'd50);
		send_pixel(8'd50, 8'd100, 8'd200);

		// Random pixels across several rotation settings.
		foreach (rots[i]) begin
			write_rotation(rots[i]);
			send_pixel(8'd255, 8'd0, 8'd0);
			random_pixels(70);
		end
		write_rotation(16'($urandom));

		// Long receiver hold while pixels keep coming.
		long_hold = 1'b1;
		random_pixels(120);
		drain();

		// Final part with no idling on either side.
		quiet = 1'b1;
		write_rotation(16'($urandom));
		random_pixels(150);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// File: pixel_hue_rotation_unit.f
design/hrot_pkg.sv
design/hrot_div.sv
design/hrot_rebuild.sv
design/pixel_hue_rotation_unit.sv
bench/tb_top.sv
